[rtl/pnu_pkg.sv]
// ----------------------------------------------------------------------------
// pnu_pkg
// Shared types and constants for the nearest-neighbour pixel upscaler.
// ----------------------------------------------------------------------------
package pnu_pkg;

    // Fixed field widths of the configuration registers and the pixel.
    localparam int SCALE_W      = 5;
    localparam int WIDTH_W      = 11;
    localparam int HEIGHT_W     = 13;
    localparam int ROWS_W       = 12;
    localparam int PIX_W        = 24;
    localparam int HEIGHT_LIMIT = 4096;

    // Default sizes handed to the top level.
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_FACTOR = 16;

    // Configuration port geometry.
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    // Kinds of input transfer.
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_PULL = 1'b1;

    // Register indexes on the configuration port (byte address / 4).
    typedef enum logic [1:0] {
        REG_SCALE  = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } t_reg_idx;

    // Current configuration as seen by the sequencer.
    typedef struct packed {
        logic [SCALE_W-1:0]  scale;
        logic [WIDTH_W-1:0]  width;
        logic [HEIGHT_W-1:0] height;
    } t_cfg;

    // Flags of one output transfer, settled when the pull is accepted.
    typedef struct packed {
        logic is_padding;
        logic row_end;
        logic image_end;
    } t_pull_info;

endpackage

[rtl/pnu_regs.sv]
// ----------------------------------------------------------------------------
// pnu_regs
// Configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
module pnu_regs
    import pnu_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite;

    // Register write decode; writes beyond the last register are dropped.
    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_SCALE:  n_cfg.scale  = pwdata[SCALE_W-1:0];
                REG_WIDTH:  n_cfg.width  = pwdata[WIDTH_W-1:0];
                REG_HEIGHT: n_cfg.height = pwdata[HEIGHT_W-1:0];
                default:    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale  <= SCALE_W'(1);
            r_cfg.width  <= WIDTH_W'(1);
            r_cfg.height <= HEIGHT_W'(1);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Read-back of the addressed register.
    always_comb begin
        unique case (reg_idx)
            REG_SCALE:  prdata = APB_DW'(r_cfg.scale);
            REG_WIDTH:  prdata = APB_DW'(r_cfg.width);
            REG_HEIGHT: prdata = APB_DW'(r_cfg.height);
            default:    prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/pnu_row_store.sv]
// ----------------------------------------------------------------------------
// pnu_row_store
// One-row pixel store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pnu_row_store
    import pnu_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [PIX_W-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [PIX_W-1:0] o_rd_data
);

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/pnu_seq.sv]
// ----------------------------------------------------------------------------
// pnu_seq
// Column, repeat and row counters; generates row store addresses and the
// flags of each output transfer.
// ----------------------------------------------------------------------------
module pnu_seq
    import pnu_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_FACTOR = DEF_MAX_FACTOR,
    parameter int CW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cfg          i_cfg,
    input  logic          i_accept,
    input  logic          i_kind,
    output logic          o_wr_en,
    output logic [CW-1:0] o_wr_addr,
    output logic          o_rd_en,
    output logic [CW-1:0] o_rd_addr,
    output t_pull_info    o_info
);

    // Working widths: effective bounds and counter-plus-one compares.
    localparam int EW0 = $clog2(MAX_WIDTH + 1);
    localparam int EW  = (EW0 > WIDTH_W) ? EW0 : WIDTH_W;
    localparam int XW  = (EW > CW + 1) ? EW : CW + 1;
    localparam int SW0 = $clog2(MAX_FACTOR + 1);
    localparam int SW  = (SW0 > SCALE_W) ? SW0 : SCALE_W;
    localparam int RW  = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
    localparam int YW  = (SW > RW + 1) ? SW : RW + 1;

    logic [CW-1:0]     r_load_col,  n_load_col;
    logic [CW-1:0]     r_src_col,   n_src_col;
    logic [RW-1:0]     r_col_rep,   n_col_rep;
    logic [RW-1:0]     r_row_rep,   n_row_rep;
    logic [ROWS_W-1:0] r_rows,      n_rows;
    logic [1:0]        r_pad_left,  n_pad_left;

    logic [XW-1:0]       eff_width;
    logic [YW-1:0]       eff_scale;
    logic [HEIGHT_W-1:0] eff_height;
    logic [1:0]          pad_count;
    logic                finish;
    t_pull_info          info;

    // Effective register values: zero acts as one, oversize saturates.
    always_comb begin
        if (i_cfg.width == '0) begin
            eff_width = XW'(1);
        end else if (EW'(i_cfg.width) > EW'(MAX_WIDTH)) begin
            eff_width = XW'(MAX_WIDTH);
        end else begin
            eff_width = XW'(i_cfg.width);
        end
        if (i_cfg.scale == '0) begin
            eff_scale = YW'(1);
        end else if (SW'(i_cfg.scale) > SW'(MAX_FACTOR)) begin
            eff_scale = YW'(MAX_FACTOR);
        end else begin
            eff_scale = YW'(i_cfg.scale);
        end
        if (i_cfg.height == '0) begin
            eff_height = HEIGHT_W'(1);
        end else if (i_cfg.height > HEIGHT_W'(HEIGHT_LIMIT)) begin
            eff_height = HEIGHT_W'(HEIGHT_LIMIT);
        end else begin
            eff_height = i_cfg.height;
        end
    end

    // Padding bytes after a row: (width * scale) mod 4.
    assign pad_count = 2'(eff_width[1:0] * eff_scale[1:0]);

    // Counter update for loads and pulls.
    always_comb begin
        n_load_col = r_load_col;
        n_src_col  = r_src_col;
        n_col_rep  = r_col_rep;
        n_row_rep  = r_row_rep;
        n_rows     = r_rows;
        n_pad_left = r_pad_left;
        info       = '0;
        finish     = 1'b0;

        if (i_accept && !i_kind) begin
            // A load writes the next column, wrapping after the row width.
            if (XW'(r_load_col) + XW'(1) >= eff_width) begin
                n_load_col = '0;
            end else begin
                n_load_col = r_load_col + CW'(1);
            end
        end

        if (i_accept && i_kind) begin
            if (r_pad_left != 2'd0) begin
                // Padding byte after the pixels of a row.
                info.is_padding = 1'b1;
                n_pad_left      = r_pad_left - 2'd1;
                if (r_pad_left == 2'd1) begin
                    finish = 1'b1;
                end
            end else if (YW'(r_col_rep) + YW'(1) >= eff_scale) begin
                // Last repeat of this source pixel.
                n_col_rep = '0;
                if (XW'(r_src_col) + XW'(1) >= eff_width) begin
                    n_src_col = '0;
                    if (pad_count == 2'd0) begin
                        finish = 1'b1;
                    end else begin
                        n_pad_left = pad_count;
                    end
                end else begin
                    n_src_col = r_src_col + CW'(1);
                end
            end else begin
                n_col_rep = r_col_rep + RW'(1);
            end
        end

        // End of an output row: advance the row repeat and row counters.
        if (finish) begin
            info.row_end = 1'b1;
            if (YW'(r_row_rep) + YW'(1) >= eff_scale) begin
                n_row_rep = '0;
                if (HEIGHT_W'(r_rows) + HEIGHT_W'(1) >= eff_height) begin
                    n_rows         = '0;
                    info.image_end = 1'b1;
                end else begin
                    n_rows = r_rows + ROWS_W'(1);
                end
            end else begin
                n_row_rep = r_row_rep + RW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_col <= '0;
            r_src_col  <= '0;
            r_col_rep  <= '0;
            r_row_rep  <= '0;
            r_rows     <= '0;
            r_pad_left <= '0;
        end else begin
            r_load_col <= n_load_col;
            r_src_col  <= n_src_col;
            r_col_rep  <= n_col_rep;
            r_row_rep  <= n_row_rep;
            r_rows     <= n_rows;
            r_pad_left <= n_pad_left;
        end
    end

    // Row store access for the accepted item.
    assign o_wr_en   = i_accept && !i_kind;
    assign o_wr_addr = r_load_col;
    assign o_rd_en   = i_accept && i_kind;
    assign o_rd_addr = r_src_col;
    assign o_info    = info;

endmodule

[rtl/pixel_nearest_upscaler_core.sv]
// ----------------------------------------------------------------------------
// pixel_nearest_upscaler_core
// Nearest-neighbour integer upscaler for 24-bit BGR pixels.
// ----------------------------------------------------------------------------
// The input channel (i_valid / o_ready) carries two kinds of transfer: a load
// (i_kind low) writes one pixel into the next column of the row store and
// gives no output; a pull (i_kind high) produces one output transfer.
// Each stored pixel is repeated scale_factor times across a row and the row
// is pulled scale_factor times; every output row ends with
// (width * scale) mod 4 zero padding bytes, flagged by o_is_padding.
// o_row_end and o_image_end mark the last transfer of a row and an image.
// Configuration goes through the APB-style port, written while idle.
// Throughput: one item per clock in both directions while the receiver keeps
// up. A pull is read from the row store into the read stage when accepted and
// then moves into the output register, which drives o_valid.
// Reset clears all counters and sets every register to 1; the row store is
// not cleared, so a row must be loaded before it is pulled.
// When the receiver stalls, the output register and the read stage hold one
// result each; the input channel keeps accepting until both are full.
// ----------------------------------------------------------------------------
module pixel_nearest_upscaler_core
    import pnu_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_FACTOR = DEF_MAX_FACTOR
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    // Input channel
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_kind,
    input  logic [7:0]        i_blue,
    input  logic [7:0]        i_green,
    input  logic [7:0]        i_red,
    // Output channel
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_is_padding,
    output logic [7:0]        o_out_blue,
    output logic [7:0]        o_out_green,
    output logic [7:0]        o_out_red,
    output logic              o_row_end,
    output logic              o_image_end
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    t_cfg             cfg;
    logic             accept;
    logic             s1_adv;
    logic             wr_en;
    logic [CW-1:0]    wr_addr;
    logic             rd_en;
    logic [CW-1:0]    rd_addr;
    logic [PIX_W-1:0] rd_data;
    t_pull_info       pull_info;

    logic             r_s1_valid;
    t_pull_info       r_s1_info;
    logic             r_out_valid;
    t_pull_info       r_out_info;
    logic [PIX_W-1:0] r_out_pix;

    pnu_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pnu_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR),
        .CW         (CW)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_accept  (accept),
        .i_kind    (i_kind),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .o_info    (pull_info)
    );

    pnu_row_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data ({i_red, i_green, i_blue}),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Handshake: the read stage moves on whenever the output register is empty or taken.
    assign s1_adv  = !r_out_valid || i_ready;
    assign o_ready = !r_s1_valid || s1_adv;
    assign accept  = i_valid && o_ready;

    // Read stage: flags wait here while the row store read completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= accept && i_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_s1_info <= pull_info;
        end
    end

    // Output register; padding bytes carry zero colour.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_valid) begin
            r_out_info <= r_s1_info;
            r_out_pix  <= r_s1_info.is_padding ? '0 : rd_data;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_is_padding = r_out_info.is_padding;
    assign o_out_blue   = r_out_pix[7:0];
    assign o_out_green  = r_out_pix[15:8];
    assign o_out_red    = r_out_pix[23:16];
    assign o_row_end    = r_out_info.row_end;
    assign o_image_end  = r_out_info.image_end;

    // A padding transfer never carries colour.
    a_pad_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_padding |-> (r_out_pix == '0))
        else $error("padding transfer with non-zero colour");

    // The image end is always also a row end.
    a_image_row : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_image_end |-> o_row_end)
        else $error("image end without row end");

    // A result in the read stage is never dropped while the output stalls.
    a_s1_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv |=> r_s1_valid && $stable(r_s1_info))
        else $error("read stage result lost during stall");

endmodule

[tb/pixel_nearest_upscaler_checker.sv]
// ----------------------------------------------------------------------------
// pixel_nearest_upscaler_checker
// Watches the upscaler's ports, predicts every output transfer and compares.
// ----------------------------------------------------------------------------
// The checker mirrors the configuration writes seen on the register port and
// keeps its own row store and row/column counters. Each accepted load updates
// the mirrored store; each accepted pull queues the output transfer it should
// cause. Output transfers are compared field by field, in order, with the
// queue. The number of mismatches and the number of outstanding transfers go
// back to the test top.
// ----------------------------------------------------------------------------
module pixel_nearest_upscaler_checker
    import pnu_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_FACTOR = DEF_MAX_FACTOR
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Register port, observed
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,
    input  logic              i_pready,
    // Input channel, observed
    input  logic              i_in_valid,
    input  logic              i_in_ready,
    input  logic              i_kind,
    input  logic [7:0]        i_blue,
    input  logic [7:0]        i_green,
    input  logic [7:0]        i_red,
    // Output channel, observed
    input  logic              i_out_valid,
    input  logic              i_out_ready,
    input  logic              i_is_padding,
    input  logic [7:0]        i_out_blue,
    input  logic [7:0]        i_out_green,
    input  logic [7:0]        i_out_red,
    input  logic              i_row_end,
    input  logic              i_image_end,
    // Status for the test top
    output int unsigned       o_fail_count,
    output int unsigned       o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // One output transfer as the block should present it.
    typedef struct packed {
        logic       is_padding;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       row_end;
        logic       image_end;
    } t_upscaled_px;

    // Mirrored registers.
    logic [SCALE_W-1:0]  scale_q;
    logic [WIDTH_W-1:0]  width_q;
    logic [HEIGHT_W-1:0] height_q;

    // Mirrored datapath state.
    logic [PIX_W-1:0] line_buf [MAX_WIDTH];
    int unsigned      load_col;
    int unsigned      src_col;
    int unsigned      col_rep;
    int unsigned      row_rep;
    int unsigned      rows_out;
    int unsigned      pads_owed;

    t_upscaled_px upscaled_due[$];
    int unsigned  mismatch_count = 0;
    int unsigned  transfers_seen = 0;

    // A register of zero behaves as one; oversize values saturate.
    function automatic int unsigned clip(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // Step past the end of one output row; true when the image is complete.
    function automatic logic close_row();
        if (row_rep + 1 >= clip(32'(scale_q), MAX_FACTOR)) begin
            row_rep = 0;
            if (rows_out + 1 >= clip(32'(height_q), HEIGHT_LIMIT)) begin
                rows_out = 0;
                return 1'b1;
            end
            rows_out++;
            return 1'b0;
        end
        row_rep++;
        return 1'b0;
    endfunction

    // A load writes the next column and wraps after the row width.
    function automatic void store_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
        if (load_col < MAX_WIDTH) line_buf[load_col] = {r, g, b};
        if (load_col + 1 >= clip(32'(width_q), MAX_WIDTH)) load_col = 0;
        else load_col++;
    endfunction

    // A pull yields either a repeated pixel or one of the row's padding bytes.
    function automatic t_upscaled_px next_output_pixel();
        t_upscaled_px px;
        int unsigned  w;
        int unsigned  s;
        int unsigned  pad;
        w  = clip(32'(width_q), MAX_WIDTH);
        s  = clip(32'(scale_q), MAX_FACTOR);
        px = '0;
        if (pads_owed != 0) begin
            px.is_padding = 1'b1;
            pads_owed--;
            if (pads_owed == 0) begin
                px.row_end   = 1'b1;
                px.image_end = close_row();
            end
        end else begin
            if (src_col < MAX_WIDTH) {px.red, px.green, px.blue} = line_buf[src_col];
            if (col_rep + 1 >= s) begin
                col_rep = 0;
                if (src_col + 1 >= w) begin
                    // Rows are padded to a multiple of four bytes.
                    pad     = ((w % 4) * (s % 4)) % 4;
                    src_col = 0;
                    if (pad == 0) begin
                        px.row_end   = 1'b1;
                        px.image_end = close_row();
                    end else begin
                        pads_owed = pad;
                    end
                end else begin
                    src_col++;
                end
            end else begin
                col_rep++;
            end
        end
        return px;
    endfunction

    // Prints one line per mismatch and counts every one.
    task automatic report_mismatch(string what);
        mismatch_count++;
        $display("[%0t] mismatch on output transfer %0d: %s", $time, transfers_seen, what);
    endtask

    task automatic check_field(string name, logic [7:0] want_v, logic [7:0] got_v);
        if (got_v !== want_v)
            report_mismatch($sformatf("%s expected %0h got %0h", name, want_v, got_v));
    endtask

    // Sample every channel at the clock edge.
    always @(posedge i_clk) begin
        t_upscaled_px got;
        t_upscaled_px want;
        if (!i_rst_n) begin
            scale_q   = SCALE_W'(1);
            width_q   = WIDTH_W'(1);
            height_q  = HEIGHT_W'(1);
            load_col  = 0;
            src_col   = 0;
            col_rep   = 0;
            row_rep   = 0;
            rows_out  = 0;
            pads_owed = 0;
            upscaled_due.delete();
        end else begin
            // Register writes.
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[3:2]))
                    REG_SCALE:  scale_q  = i_pwdata[SCALE_W-1:0];
                    REG_WIDTH:  width_q  = i_pwdata[WIDTH_W-1:0];
                    REG_HEIGHT: height_q = i_pwdata[HEIGHT_W-1:0];
                    default: ;
                endcase
            end

            // Input transfers.
            if (i_in_valid && i_in_ready) begin
                if (i_kind == KIND_PULL) upscaled_due.push_back(next_output_pixel());
                else store_pixel(i_blue, i_green, i_red);
            end

            // Output transfers.
            if (i_out_valid && i_out_ready) begin
                transfers_seen++;
                got = '{i_is_padding, i_out_blue, i_out_green, i_out_red,
                        i_row_end, i_image_end};
                if (upscaled_due.size() == 0) begin
                    report_mismatch("output transfer with no pull waiting for it");
                end else begin
                    want = upscaled_due.pop_front();
                    check_field("is_padding", 8'(want.is_padding), 8'(got.is_padding));
                    check_field("out_blue", want.blue, got.blue);
                    check_field("out_green", want.green, got.green);
                    check_field("out_red", want.red, got.red);
                    check_field("row_end", 8'(want.row_end), 8'(got.row_end));
                    check_field("image_end", 8'(want.image_end), 8'(got.image_end));
                end
            end
        end
        o_pending    <= upscaled_due.size();
        o_fail_count <= mismatch_count;
    end

endmodule

[tb/pixel_nearest_upscaler_core_test.sv]
// ----------------------------------------------------------------------------
// pixel_nearest_upscaler_core_test
// Stimulus and verdict for the nearest-neighbour pixel upscaler.
// ----------------------------------------------------------------------------
// After reset a short directed sequence covers the reset configuration, the
// zero registers, colour extremes, ignored colour bits on pulls and one and
// three padding bytes. A phase at saturated register values follows, then
// random phases of loads and pulls under changing settings and idling
// patterns. Before any pull can reach a column, every column up to the
// current row width has been loaded. The checker beside the block predicts
// and compares; this module makes the stimulus and reports the outcome.
// ----------------------------------------------------------------------------
module pixel_nearest_upscaler_core_test
    import pnu_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_ITEMS   = 280;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned HOLD_CYCLES    = 64;
    localparam int unsigned WATCHDOG_LIMIT = 2000;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic              i_kind  = KIND_LOAD;
    logic [7:0]        i_blue  = '0;
    logic [7:0]        i_green = '0;
    logic [7:0]        i_red   = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic              o_is_padding;
    logic [7:0]        o_out_blue;
    logic [7:0]        o_out_green;
    logic [7:0]        o_out_red;
    logic              o_row_end;
    logic              o_image_end;

    int unsigned fail_count;
    int unsigned pending;

    // Idling controls, in percent of cycles.
    int unsigned send_idle_pct  = 0;
    int unsigned take_stall_pct = 0;
    // Hold-off requests from the sequence and those served by the receiver.
    int unsigned hold_req       = 0;
    int unsigned hold_ack       = 0;

    // Columns known to hold a loaded pixel, counted from column zero.
    int unsigned store_covered = 0;
    int unsigned width_now     = 1;
    int unsigned items_sent    = 0;

    pixel_nearest_upscaler_core u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_blue       (i_blue),
        .i_green      (i_green),
        .i_red        (i_red),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_is_padding (o_is_padding),
        .o_out_blue   (o_out_blue),
        .o_out_green  (o_out_green),
        .o_out_red    (o_out_red),
        .o_row_end    (o_row_end),
        .o_image_end  (o_image_end)
    );

    pixel_nearest_upscaler_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_kind       (i_kind),
        .i_blue       (i_blue),
        .i_green      (i_green),
        .i_red        (i_red),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_is_padding (o_is_padding),
        .i_out_blue   (o_out_blue),
        .i_out_green  (o_out_green),
        .i_out_red    (o_out_red),
        .i_row_end    (o_row_end),
        .i_image_end  (o_image_end),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 50 MHz clock.
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Receiver: random stalls, or one long hold-off when requested.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_ack) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_ack = hold_req;
            end else begin
                i_ready <= ($urandom_range(99) >= take_stall_pct);
            end
        end
    end

    // Ends the run when no transfer of any kind happens for too long.
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable)) quiet = 0;
            else quiet++;
        end
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int unsigned active_width(int unsigned v);
        if (v == 0) return 1;
        if (v > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
        return v;
    endfunction

    // Offers one item, with random idle cycles ahead of it, until accepted.
    task automatic send_item(logic kind, logic [7:0] b, logic [7:0] g, logic [7:0] r);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid <= 1'b1;
        i_kind  <= kind;
        i_blue  <= b;
        i_green <= g;
        i_red   <= r;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
    endtask

    // Pulls carry random colour bits, which the block must ignore.
    task automatic send_random(logic kind);
        send_item(kind, 8'($urandom()), 8'($urandom()), 8'($urandom()));
    endtask

    // Stops offering and waits until every pull has produced its transfer.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Setup then access cycle; psel stays high between back-to-back writes.
    task automatic write_reg(t_reg_idx idx, int unsigned value, int field_w);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DW'(($urandom() << field_w) | value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    // Reconfigures while idle, then loads a full row if the new width
    // reaches columns that have never been written.
    task automatic set_config(int unsigned s, int unsigned w, int unsigned h);
        drain();
        write_reg(REG_SCALE, s, SCALE_W);
        write_reg(REG_WIDTH, w, WIDTH_W);
        write_reg(REG_HEIGHT, h, HEIGHT_W);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        width_now = active_width(w);
        if (width_now > store_covered) begin
            // One more load than the width covers a start beyond the row.
            repeat (width_now + 1) send_random(KIND_LOAD);
            store_covered = width_now;
        end
    endtask

    function automatic int unsigned pick_scale();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(4, 1);
        if (r < 90) return $urandom_range(16, 5);
        if (r < 95) return 0;
        return $urandom_range(31, 17);
    endfunction

    function automatic int unsigned pick_width();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) return $urandom_range(8, 1);
        if (r < 90) return $urandom_range(64, 9);
        if (r < 95) return 0;
        return $urandom_range(2047, 1025);
    endfunction

    function automatic int unsigned pick_height();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 80) return $urandom_range(4, 1);
        if (r < 90) return $urandom_range(40, 5);
        if (r < 95) return 0;
        return $urandom_range(8191, 4097);
    endfunction

    // Main sequence.
    initial begin
        int unsigned phase;
        int unsigned n;
        int unsigned random_start;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: one pixel, one padding byte closing row and image.
        send_item(KIND_LOAD, 8'h00, 8'hFF, 8'hA5);
        store_covered = 1;
        send_item(KIND_PULL, 8'hFF, 8'hFF, 8'hFF);
        send_item(KIND_PULL, 8'h00, 8'h00, 8'h00);
        send_item(KIND_LOAD, 8'hFF, 8'h00, 8'h5A);
        send_item(KIND_PULL, 8'h5A, 8'hC3, 8'h3C);
        send_item(KIND_PULL, 8'hA5, 8'h3C, 8'hC3);

        // Zero registers behave as one.
        set_config(0, 0, 0);
        repeat (2) send_random(KIND_PULL);

        // Three pixels per row and three padding bytes, pulled for one of two rows.
        set_config(1, 3, 2);
        repeat (6) send_random(KIND_PULL);

        // Saturated registers, first with every register bit set, then at the limits.
        set_config(31, 2047, 8191);
        repeat (40) send_random(KIND_PULL);
        set_config(16, 1024, 4096);
        repeat (20) send_random(KIND_PULL);

        // Random phases, cycling through the idling patterns.
        random_start = items_sent;
        phase        = 0;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  take_stall_pct = 0;  end
                1: begin send_idle_pct = 58; take_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  take_stall_pct = 58; end
                default: begin send_idle_pct = 33; take_stall_pct = 33; end
            endcase
            set_config(pick_scale(), pick_width(), pick_height());
            n = $urandom_range(80, 20);

            if (phase % 8 == 2) begin
                // Long receiver hold-off while pulls keep coming back to back.
                send_idle_pct = 0;
                hold_req++;
                repeat (30) send_random(KIND_PULL);
            end

            repeat (n) begin
                if ($urandom_range(99) < 75) send_random(KIND_PULL);
                else send_random(KIND_LOAD);
                // Mid-phase pause until every transfer has come back.
                if (phase % 8 == 3 && items_sent % 64 == 0) drain();
            end
            phase++;
        end

        drain();
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
